// ===== src/pdfc_pkg.sv =====
// shared types, widths and helpers for the pwm duty and frequency capture core
// no dependencies; every other file refers to this package by scoped names
`timescale 1ns / 1ps
`default_nettype none

package pdfc_pkg;

  localparam int COUNT_BITS = 16;
  localparam int CLK_HZ_W   = 24;
  localparam logic [CLK_HZ_W-1:0] CLK_HZ_RESET = 24'd1000000;

  localparam int DUTY_SCALE = 100;
  localparam int SCALE_W    = 7;

  // shared divider: numerator holds high*100 or clk_hz, divisor holds the period
  localparam int DIV_NUM_W = (COUNT_BITS + SCALE_W > CLK_HZ_W) ? COUNT_BITS + SCALE_W
                                                                : CLK_HZ_W;
  localparam int DIV_DEN_W = COUNT_BITS;
  localparam int DIV_CNT_W = $clog2(DIV_NUM_W + 1);

  localparam logic CMD_START = 1'b0;
  localparam logic CMD_TICK  = 1'b1;

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_RISE1,
    PH_RISE2,
    PH_FALL
  } phase_t;

  typedef enum logic [2:0] {
    ST_RUN,
    ST_DUTY,
    ST_DUTY_WAIT,
    ST_FREQ,
    ST_FREQ_WAIT,
    ST_LOAD
  } ctrl_state_t;

  typedef struct packed {
    logic item_accept;
    logic div_duty;
    logic div_freq;
    logic capture_duty;
    logic capture_freq;
    logic load_out;
  } dp_cmd_t;

  typedef struct packed {
    logic meas_done;
    logic div_done;
  } dp_status_t;

  function automatic logic [15:0] sat16(input logic [COUNT_BITS-1:0] v);
    logic [15:0] r;
    if (32'(v) > 32'd65535) begin
      r = 16'hFFFF;
    end else begin
      r = 16'(v);
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== src/pdfc_div.sv =====
// restoring divider, one quotient bit per cycle
// depends on pdfc_pkg for its widths
`timescale 1ns / 1ps
`default_nettype none

module pdfc_div (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          start,
  input  wire logic [pdfc_pkg::DIV_NUM_W-1:0] num,
  input  wire logic [pdfc_pkg::DIV_DEN_W-1:0] den,
  output logic                               done,
  output logic [pdfc_pkg::DIV_NUM_W-1:0]      quo
);

  logic [pdfc_pkg::DIV_DEN_W-1:0] rem;
  logic [pdfc_pkg::DIV_DEN_W-1:0] den_r;
  logic [pdfc_pkg::DIV_CNT_W-1:0] cnt;
  logic [pdfc_pkg::DIV_DEN_W:0]   trial;
  logic [pdfc_pkg::DIV_DEN_W:0]   diff;
  logic                           ge;

  assign trial = {rem, quo[pdfc_pkg::DIV_NUM_W-1]};
  assign diff  = trial - {1'b0, den_r};
  assign ge    = trial >= {1'b0, den_r};

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        rem   <= '0;
        quo   <= num;
        den_r <= den;
        cnt   <= pdfc_pkg::DIV_CNT_W'(pdfc_pkg::DIV_NUM_W);
      end else if (cnt != '0) begin
        rem <= ge ? diff[pdfc_pkg::DIV_DEN_W-1:0] : trial[pdfc_pkg::DIV_DEN_W-1:0];
        quo <= {quo[pdfc_pkg::DIV_NUM_W-2:0], ge};
        cnt <= cnt - 1'b1;
        if (cnt == pdfc_pkg::DIV_CNT_W'(1)) begin
          done <= 1'b1;
        end
      end
    end
  end

endmodule

`default_nettype wire

// ===== src/pdfc_datapath.sv =====
// tick counter, edge captures, period and high time, result registers
// depends on pdfc_pkg and pdfc_div
`timescale 1ns / 1ps
`default_nettype none

module pdfc_datapath (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire pdfc_pkg::dp_cmd_t             cmd_bus,
  output pdfc_pkg::dp_status_t               status,
  input  wire logic                          cmd,
  input  wire logic                          pin_level,
  input  wire logic                          cfg_we,
  input  wire logic [pdfc_pkg::CLK_HZ_W-1:0] cfg_data,
  output logic [7:0]                         duty_percent,
  output logic [15:0]                        freq_hz,
  output logic [15:0]                        period_ticks,
  output logic [15:0]                        high_ticks
);

  localparam int CB = pdfc_pkg::COUNT_BITS;
  localparam int NW = pdfc_pkg::DIV_NUM_W;

  pdfc_pkg::phase_t       phase, phase_next;
  logic [CB-1:0]          tick_count, tick_count_next;
  logic [CB-1:0]          first_rise, second_rise;
  logic                   last_level;
  logic [pdfc_pkg::CLK_HZ_W-1:0] clk_hz;
  logic [CB-1:0]          period_r, high_r;
  logic [7:0]             duty_r;
  logic [15:0]            freq_r;

  logic                   tick, rise, fall, order_ok, restart, meas_done;
  logic [CB-1:0]          period, high_raw, high_fix;
  logic [CB+pdfc_pkg::SCALE_W-1:0] high_scaled;
  logic                   div_start;
  logic [NW-1:0]          div_num;
  logic                   div_done;
  logic [NW-1:0]          div_quo;

  assign tick     = cmd_bus.item_accept && (cmd == pdfc_pkg::CMD_TICK);
  assign rise     = pin_level && !last_level;
  assign fall     = !pin_level && last_level;
  assign order_ok = (first_rise < second_rise) && (second_rise < tick_count);
  assign period   = second_rise - first_rise;
  assign high_raw = tick_count - second_rise;
  // narrow pulse: fall seen after the following rise
  assign high_fix = (high_raw >= period) ? high_raw - period : high_raw;

  always_comb begin
    phase_next      = phase;
    tick_count_next = tick_count + 1'b1;
    restart         = 1'b0;
    meas_done       = 1'b0;
    unique case (phase)
      pdfc_pkg::PH_IDLE: begin
      end
      pdfc_pkg::PH_RISE1: begin
        if (rise) phase_next = pdfc_pkg::PH_RISE2;
      end
      pdfc_pkg::PH_RISE2: begin
        if (rise) phase_next = pdfc_pkg::PH_FALL;
      end
      pdfc_pkg::PH_FALL: begin
        if (fall) begin
          if (order_ok) begin
            meas_done  = tick;
            phase_next = pdfc_pkg::PH_IDLE;
          end else begin
            restart    = 1'b1;
            phase_next = pdfc_pkg::PH_RISE1;
          end
        end
      end
      default: begin
      end
    endcase
    if (restart) tick_count_next = '0;
  end

  assign status.meas_done = meas_done;
  assign status.div_done  = div_done;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= pdfc_pkg::PH_IDLE;
      tick_count <= '0;
      first_rise <= '0;
      second_rise <= '0;
      last_level <= 1'b0;
      clk_hz     <= pdfc_pkg::CLK_HZ_RESET;
    end else begin
      if (cfg_we) clk_hz <= cfg_data;
      if (cmd_bus.item_accept) begin
        if (cmd == pdfc_pkg::CMD_START) begin
          tick_count <= '0;
          phase      <= pdfc_pkg::PH_RISE1;
        end else begin
          last_level <= pin_level;
          tick_count <= tick_count_next;
          phase      <= phase_next;
          if (phase == pdfc_pkg::PH_RISE1 && rise) first_rise  <= tick_count;
          if (phase == pdfc_pkg::PH_RISE2 && rise) second_rise <= tick_count;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (meas_done) begin
      period_r <= period;
      high_r   <= high_fix;
    end
    if (div_done && cmd_bus.capture_duty) begin
      duty_r <= (div_quo >= NW'(255)) ? 8'd255 : 8'(div_quo) + 8'd1;
    end
    if (div_done && cmd_bus.capture_freq) begin
      freq_r <= (div_quo > NW'(65535)) ? 16'hFFFF : 16'(div_quo);
    end
    if (cmd_bus.load_out) begin
      duty_percent <= duty_r;
      freq_hz      <= freq_r;
      period_ticks <= pdfc_pkg::sat16(period_r);
      high_ticks   <= pdfc_pkg::sat16(high_r);
    end
  end

  assign high_scaled = high_r * pdfc_pkg::SCALE_W'(pdfc_pkg::DUTY_SCALE);
  assign div_start   = cmd_bus.div_duty || cmd_bus.div_freq;
  assign div_num     = cmd_bus.div_duty ? NW'(high_scaled) : NW'(clk_hz);

  pdfc_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (div_num),
    .den   (period_r),
    .done  (div_done),
    .quo   (div_quo)
  );

endmodule

`default_nettype wire

// ===== src/pdfc_ctrl.sv =====
// controller: handshakes and sequencing of the two divisions per measurement
// depends on pdfc_pkg
`timescale 1ns / 1ps
`default_nettype none

module pdfc_ctrl (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output pdfc_pkg::dp_cmd_t         cmd_bus,
  input  wire pdfc_pkg::dp_status_t status
);

  pdfc_pkg::ctrl_state_t state, state_next;
  logic out_free;

  assign out_free = !out_valid || out_ready;

  always_comb begin
    state_next = state;
    unique case (state)
      pdfc_pkg::ST_RUN:       if (status.meas_done) state_next = pdfc_pkg::ST_DUTY;
      pdfc_pkg::ST_DUTY:      state_next = pdfc_pkg::ST_DUTY_WAIT;
      pdfc_pkg::ST_DUTY_WAIT: if (status.div_done) state_next = pdfc_pkg::ST_FREQ;
      pdfc_pkg::ST_FREQ:      state_next = pdfc_pkg::ST_FREQ_WAIT;
      pdfc_pkg::ST_FREQ_WAIT: if (status.div_done) state_next = pdfc_pkg::ST_LOAD;
      pdfc_pkg::ST_LOAD:      if (out_free) state_next = pdfc_pkg::ST_RUN;
      default:                state_next = pdfc_pkg::ST_RUN;
    endcase
  end

  always_comb begin
    in_ready = 1'b0;
    cmd_bus  = '0;
    unique case (state)
      pdfc_pkg::ST_RUN: begin
        in_ready             = 1'b1;
        cmd_bus.item_accept  = in_valid;
      end
      pdfc_pkg::ST_DUTY:      cmd_bus.div_duty     = 1'b1;
      pdfc_pkg::ST_DUTY_WAIT: cmd_bus.capture_duty = 1'b1;
      pdfc_pkg::ST_FREQ:      cmd_bus.div_freq     = 1'b1;
      pdfc_pkg::ST_FREQ_WAIT: cmd_bus.capture_freq = 1'b1;
      pdfc_pkg::ST_LOAD:      cmd_bus.load_out     = out_free;
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= pdfc_pkg::ST_RUN;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd_bus.load_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  a_meas_starts_duty: assert property (@(posedge clk) disable iff (rst)
    status.meas_done |=> state == pdfc_pkg::ST_DUTY)
    else $error("completed measurement did not start the duty division");

  a_meas_only_in_run: assert property (@(posedge clk) disable iff (rst)
    status.meas_done |-> state == pdfc_pkg::ST_RUN && in_valid)
    else $error("measurement completed without an accepted item");

  a_no_div_done_in_run: assert property (@(posedge clk) disable iff (rst)
    state == pdfc_pkg::ST_RUN |-> !status.div_done)
    else $error("divider finished while no division was pending");

  a_load_only_when_free: assert property (@(posedge clk) disable iff (rst)
    cmd_bus.load_out |-> out_free)
    else $error("result register overwritten while still held");

  a_load_sets_valid: assert property (@(posedge clk) disable iff (rst)
    cmd_bus.load_out |=> out_valid)
    else $error("loaded result not presented");

endmodule

`default_nettype wire

// ===== src/pwm_duty_frequency_capture_core.sv =====
// pwm input capture: duty, frequency, period and high time of a sampled pin
// depends on pdfc_pkg, pdfc_ctrl, pdfc_datapath (which holds pdfc_div)
//
//   channel  signals                                      direction
//   in       in_valid/in_ready, cmd, pin_level            into block
//   out      out_valid/out_ready, duty_percent, freq_hz,  out of block
//            period_ticks, high_ticks
//   cfg      cfg_valid/cfg_ready, cfg_data (clk_hz)       into block
//
// start and tick items take one cycle each, back to back.
// the item that completes a measurement holds in_ready low for two divisions on the
// one restoring divider, one quotient bit per cycle.
// the result register frees the input side; a new result waits only if the
// previous one is still not taken. reset is synchronous, no clearing pass.
`timescale 1ns / 1ps
`default_nettype none

module pwm_duty_frequency_capture_core (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic                          cmd,
  input  wire logic                          pin_level,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic [7:0]                         duty_percent,
  output logic [15:0]                        freq_hz,
  output logic [15:0]                        period_ticks,
  output logic [15:0]                        high_ticks,
  input  wire logic                          cfg_valid,
  output logic                               cfg_ready,
  input  wire logic [pdfc_pkg::CLK_HZ_W-1:0] cfg_data
);

  pdfc_pkg::dp_cmd_t    cmd_bus;
  pdfc_pkg::dp_status_t status;

  assign cfg_ready = 1'b1;

  pdfc_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd_bus   (cmd_bus),
    .status    (status)
  );

  pdfc_datapath u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd_bus      (cmd_bus),
    .status       (status),
    .cmd          (cmd),
    .pin_level    (pin_level),
    .cfg_we       (cfg_valid && cfg_ready),
    .cfg_data     (cfg_data),
    .duty_percent (duty_percent),
    .freq_hz      (freq_hz),
    .period_ticks (period_ticks),
    .high_ticks   (high_ticks)
  );

endmodule

`default_nettype wire

// ===== dv/pwm_duty_frequency_capture_core_tb.sv =====
// testbench for pwm_duty_frequency_capture_core: sends start and tick items, predicts every
// duty, frequency, period and high-time result and checks it field by field
// depends on pdfc_pkg and the core rtl
`timescale 1ns / 1ps

module pwm_duty_frequency_capture_core_tb;

  localparam int CYCLE_LIMIT   = 1000000;
  localparam int HOLD_CYCLES   = 400;
  localparam int SETTLE_CYCLES = 64;
  localparam int MAX_REPORTS   = 10;

  typedef struct packed {
    logic [7:0]  duty;
    logic [15:0] freq;
    logic [15:0] period;
    logic [15:0] high;
  } pwm_meas_t;

  logic                          clk = 1'b0;
  logic                          rst = 1'b1;
  logic                          in_valid = 1'b0;
  logic                          in_ready;
  logic                          cmd = pdfc_pkg::CMD_START;
  logic                          pin_level = 1'b0;
  logic                          out_valid;
  logic                          out_ready = 1'b0;
  logic [7:0]                    duty_percent;
  logic [15:0]                   freq_hz;
  logic [15:0]                   period_ticks;
  logic [15:0]                   high_ticks;
  logic                          cfg_valid = 1'b0;
  logic                          cfg_ready;
  logic [pdfc_pkg::CLK_HZ_W-1:0] cfg_data = '0;

  // capture state as the block should hold it
  logic [pdfc_pkg::CLK_HZ_W-1:0] tick_hz_q = pdfc_pkg::CLK_HZ_RESET;
  pdfc_pkg::phase_t              capture_phase = pdfc_pkg::PH_IDLE;
  logic [15:0]                   tick_cnt = '0;
  logic [15:0]                   rise_a = '0;
  logic [15:0]                   rise_b = '0;
  logic                          level_q = 1'b0;

  pwm_meas_t expected_meas[$];

  int  send_idle_pct = 0;
  int  recv_idle_pct = 0;
  int  items_sent = 0;
  int  mismatch_count = 0;
  int  cycle_count = 0;
  int  hold_left = 0;
  bit  hold_req = 1'b0;

  pwm_duty_frequency_capture_core u_dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .cmd          (cmd),
    .pin_level    (pin_level),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .duty_percent (duty_percent),
    .freq_hz      (freq_hz),
    .period_ticks (period_ticks),
    .high_ticks   (high_ticks),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_data     (cfg_data)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("pwm_duty_frequency_capture_core regression: fail");
      $finish;
    end
  end

  task automatic predict_item(input logic c, input logic l);
    logic        rise;
    logic        fall;
    logic        restart;
    logic [15:0] period;
    logic [15:0] high;
    logic [31:0] duty_full;
    logic [31:0] freq_full;
    pwm_meas_t   m;
    if (c == pdfc_pkg::CMD_START) begin
      tick_cnt = '0;
      capture_phase = pdfc_pkg::PH_RISE1;
    end else begin
      rise = l && !level_q;
      fall = !l && level_q;
      level_q = l;
      restart = 1'b0;
      if (capture_phase == pdfc_pkg::PH_RISE1 && rise) begin
        rise_a = tick_cnt;
        capture_phase = pdfc_pkg::PH_RISE2;
      end else if (capture_phase == pdfc_pkg::PH_RISE2 && rise) begin
        rise_b = tick_cnt;
        capture_phase = pdfc_pkg::PH_FALL;
      end else if (capture_phase == pdfc_pkg::PH_FALL && fall) begin
        if (rise_a < rise_b && rise_b < tick_cnt) begin
          period = rise_b - rise_a;
          high = tick_cnt - rise_b;
          // narrow pulse: fall came after the following rise
          if (high >= period) begin
            high = high - period;
          end
          duty_full = ({16'd0, high} * 32'd100) / {16'd0, period} + 32'd1;
          freq_full = {8'd0, tick_hz_q} / {16'd0, period};
          m.duty = (duty_full > 32'd255) ? 8'hFF : duty_full[7:0];
          m.freq = (freq_full > 32'd65535) ? 16'hFFFF : freq_full[15:0];
          m.period = period;
          m.high = high;
          expected_meas.push_back(m);
          capture_phase = pdfc_pkg::PH_IDLE;
        end else begin
          // captures straddle a counter wrap
          restart = 1'b1;
          capture_phase = pdfc_pkg::PH_RISE1;
        end
      end
      tick_cnt = restart ? 16'd0 : tick_cnt + 16'd1;
    end
  endtask

  task automatic send_item(input logic c, input logic l);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      cmd <= 1'($urandom_range(0, 1));
      pin_level <= 1'($urandom_range(0, 1));
      @(posedge clk);
    end
    in_valid <= 1'b1;
    cmd <= c;
    pin_level <= l;
    do begin
      @(posedge clk);
    end while (!in_ready);
    predict_item(c, l);
    items_sent++;
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    while (expected_meas.size() != 0) begin
      @(posedge clk);
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_clk_hz(input logic [pdfc_pkg::CLK_HZ_W-1:0] v);
    drain_results();
    cfg_valid <= 1'b1;
    cfg_data <= v;
    do begin
      @(posedge clk);
    end while (!cfg_ready);
    cfg_valid <= 1'b0;
    tick_hz_q = v;
  endtask

  // start, optional low lead, one full period, a high pulse and its fall, idle ticks;
  // some are cut short, some are plain noise
  task automatic send_train();
    logic lvl_q[$];
    int   kind;
    int   cut;
    kind = $urandom_range(0, 99);
    if (kind < 10) begin
      repeat ($urandom_range(1, 12)) begin
        if ($urandom_range(0, 15) == 0) begin
          send_item(pdfc_pkg::CMD_START, 1'($urandom_range(0, 1)));
        end else begin
          send_item(pdfc_pkg::CMD_TICK, 1'($urandom_range(0, 1)));
        end
      end
    end else begin
      repeat ($urandom_range(0, 3)) lvl_q.push_back(1'b0);
      repeat ($urandom_range(1, 8)) lvl_q.push_back(1'b1);
      repeat ($urandom_range(1, 8)) lvl_q.push_back(1'b0);
      if ($urandom_range(0, 9) == 0) begin
        repeat ($urandom_range(9, 40)) lvl_q.push_back(1'b1);
      end else begin
        repeat ($urandom_range(1, 12)) lvl_q.push_back(1'b1);
      end
      lvl_q.push_back(1'b0);
      repeat ($urandom_range(0, 3)) lvl_q.push_back(1'($urandom_range(0, 1)));
      cut = (kind < 20) ? $urandom_range(1, lvl_q.size() - 1) : lvl_q.size();
      send_item(pdfc_pkg::CMD_START, 1'($urandom_range(0, 1)));
      for (int i = 0; i < cut; i++) begin
        send_item(pdfc_pkg::CMD_TICK, lvl_q[i]);
      end
    end
  endtask

  task automatic note_mismatch(input string what, input pwm_meas_t want, input pwm_meas_t got);
    mismatch_count++;
    if (mismatch_count <= MAX_REPORTS) begin
      $display("%0t %s: want duty %0d freq %0d period %0d high %0d", $realtime, what,
               want.duty, want.freq, want.period, want.high);
      $display("  got duty %0d freq %0d period %0d high %0d",
               got.duty, got.freq, got.period, got.high);
    end
  endtask

  // result side: check each accepted item, then pick next cycle's ready
  always @(posedge clk) begin
    pwm_meas_t got;
    pwm_meas_t want;
    if (!rst && out_valid && out_ready) begin
      got.duty = duty_percent;
      got.freq = freq_hz;
      got.period = period_ticks;
      got.high = high_ticks;
      if (expected_meas.size() == 0) begin
        note_mismatch("result with none pending", '0, got);
      end else begin
        want = expected_meas.pop_front();
        if (got.duty !== want.duty || got.freq !== want.freq ||
            got.period !== want.period || got.high !== want.high) begin
          note_mismatch("result mismatch", want, got);
        end
      end
    end
    if (hold_req && hold_left == 0) begin
      hold_left = HOLD_CYCLES;
      hold_req = 1'b0;
    end
    if (hold_left != 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  // idle ticks with pin toggles, then a start while the pin is already high
  task automatic test_idle_and_start_level();
    send_item(pdfc_pkg::CMD_TICK, 1'b1);
    send_item(pdfc_pkg::CMD_TICK, 1'b0);
    send_item(pdfc_pkg::CMD_TICK, 1'b1);
    send_item(pdfc_pkg::CMD_START, 1'b0);
    send_item(pdfc_pkg::CMD_TICK, 1'b1);
    send_item(pdfc_pkg::CMD_TICK, 1'b0);
    send_item(pdfc_pkg::CMD_TICK, 1'b1);
    send_item(pdfc_pkg::CMD_TICK, 1'b0);
    send_item(pdfc_pkg::CMD_TICK, 1'b1);
    send_item(pdfc_pkg::CMD_TICK, 1'b0);
  endtask

  // two-tick period with a long high: narrow-pulse fix, duty and frequency saturate
  task automatic test_saturation();
    write_clk_hz(24'd16000000);
    send_item(pdfc_pkg::CMD_START, 1'b1);
    send_item(pdfc_pkg::CMD_TICK, 1'b1);
    send_item(pdfc_pkg::CMD_TICK, 1'b0);
    repeat (8) send_item(pdfc_pkg::CMD_TICK, 1'b1);
    send_item(pdfc_pkg::CMD_TICK, 1'b0);
  endtask

  task automatic test_zero_clock();
    write_clk_hz('0);
    send_item(pdfc_pkg::CMD_START, 1'b0);
    send_item(pdfc_pkg::CMD_TICK, 1'b1);
    send_item(pdfc_pkg::CMD_TICK, 1'b0);
    send_item(pdfc_pkg::CMD_TICK, 1'b1);
    send_item(pdfc_pkg::CMD_TICK, 1'b0);
  endtask

  task automatic test_random_traffic(input int send_pct, input int recv_pct, input int n_items,
                                     input logic [pdfc_pkg::CLK_HZ_W-1:0] hz);
    int first_item;
    write_clk_hz(hz);
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    first_item = items_sent;
    while (items_sent - first_item < n_items) begin
      send_train();
    end
  endtask

  // receiver stalls for a long stretch while items keep coming
  task automatic test_result_backpressure();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_req = 1'b1;
    repeat (12) send_train();
    drain_results();
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_idle_and_start_level();
    test_saturation();
    test_zero_clock();
    test_random_traffic(19, 79, 650, 24'd1);
    test_random_traffic(79, 19, 650, 24'd16000000);
    test_result_backpressure();
    test_random_traffic(0, 0, 650, pdfc_pkg::CLK_HZ_W'($urandom_range(1, 16000000)));
    drain_results();
    if (mismatch_count == 0) begin
      $display("pwm_duty_frequency_capture_core regression: pass");
    end else begin
      $display("pwm_duty_frequency_capture_core regression: fail");
    end
    $finish;
  end

endmodule

// ===== pwm_duty_frequency_capture_core.f =====
src/pdfc_pkg.sv
src/pdfc_div.sv
src/pdfc_datapath.sv
src/pdfc_ctrl.sv
src/pwm_duty_frequency_capture_core.sv
dv/pwm_duty_frequency_capture_core_tb.sv
